@@ hdl/tcgr_pkg.sv @@
// ============================================================================
// tcgr_pkg - shared types and constants of the text console glyph renderer
// Holds the sequencer states, the divider result bundle, transaction codes,
// special character codes and configuration register indexes and resets.
// ============================================================================
package tcgr_pkg;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_SCROLL,
      ST_DSTART,
      ST_DIV,
      ST_PLACE,
      ST_ROWS
   } tcgr_state_type;

   // Result bundle of the iterative divider.
   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
      logic [7:0]  remainder;
   } tcgr_div_result_type;

   // Input transaction function codes.
   localparam logic FUNC_PRINT = 1'b0;
   localparam logic FUNC_FONT  = 1'b1;

   // Result transaction kinds.
   localparam logic KIND_ROW    = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   // Character codes with special handling.
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_PRINT_MIN = 8'h20;

   // Configuration register indexes.
   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] REG_GRID_COLS  = 3'd2;
   localparam logic [2:0] REG_GRID_ROWS  = 3'd3;
   localparam logic [2:0] REG_TEXT_COLOR = 3'd4;

   // Configuration register reset values.
   localparam logic [11:0] RST_ORIGIN_X   = 12'd0;
   localparam logic [11:0] RST_ORIGIN_Y   = 12'd0;
   localparam logic [7:0]  RST_GRID_COLS  = 8'd100;
   localparam logic [7:0]  RST_GRID_ROWS  = 8'd30;
   localparam logic [31:0] RST_TEXT_COLOR = 32'hFFFF_FFFF;

endpackage

@@ hdl/text_console_glyph_renderer.sv @@
// ============================================================================
// text_console_glyph_renderer - bitmap text console with 8-pixel-wide glyphs
// Draws a character stream onto a pixel framebuffer as glyph-row writes,
// keeping a character cursor over a configurable grid.
// ============================================================================
// A request transaction either writes one font byte (func 1) or prints one
// character (func 0). Font writes and ignored control codes are taken while
// the block is idle and leave it ready. After accepting a printable character
// the block holds ready low through ST_SIZE, which forms the grid size,
// ST_SCROLL, which checks for a scroll, ST_DSTART, which starts the divider,
// ST_DIV, which waits for the 16-step iterative divider that splits the
// linear cursor into column and line (one quotient bit per cycle, then its
// done flag), ST_PLACE, which places the glyph, and ST_ROWS, which emits the
// GLYPH_ROWS glyph-row transactions, one per cycle. A waiting response
// transaction that is not taken stalls ST_SCROLL and ST_ROWS. A newline holds
// ready low through the same states up to ST_DIV and produces nothing.
// When the grid is full, one scroll transaction (kind 1) precedes the rows
// and the cursor falls back to the start of the last line; the consumer must
// move the area up by GLYPH_ROWS pixels and clear the last line. The last
// glyph row of a character carries last. Configuration writes are always
// accepted but must only be issued while the block is idle. The font store
// has no reset: glyphs must be loaded before they are printed.
module text_console_glyph_renderer #(
   parameter int GLYPH_ROWS = 16,
   parameter int FONT_CHARS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_char_code,
   input  logic [11:0] req_font_addr,
   input  logic [7:0]  req_font_byte,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [12:0] rsp_pix_x,
   output logic [12:0] rsp_pix_y,
   output logic [31:0] rsp_pix_color,
   output logic [7:0]  rsp_row_mask,
   output logic        rsp_last,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tcgr_pkg::*;

   localparam int FONT_DEPTH = FONT_CHARS * GLYPH_ROWS;
   localparam int FA_W       = $clog2(FONT_DEPTH);
   localparam int ROW_W      = $clog2(GLYPH_ROWS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

   // ---------------------------------------------------------------------
   // Configuration registers. The port never stalls.
   // ---------------------------------------------------------------------
   logic [11:0] origin_x_ff, origin_y_ff;
   logic [7:0]  grid_cols_ff, grid_rows_ff;
   logic [31:0] text_color_ff;
   logic        csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= RST_ORIGIN_X;
         origin_y_ff   <= RST_ORIGIN_Y;
         grid_cols_ff  <= RST_GRID_COLS;
         grid_rows_ff  <= RST_GRID_ROWS;
         text_color_ff <= RST_TEXT_COLOR;
      end else if (csr_wr) begin
         case (csr_index)
            REG_ORIGIN_X:   origin_x_ff   <= csr_wdata[11:0];
            REG_ORIGIN_Y:   origin_y_ff   <= csr_wdata[11:0];
            REG_GRID_COLS:  grid_cols_ff  <= csr_wdata[7:0];
            REG_GRID_ROWS:  grid_rows_ff  <= csr_wdata[7:0];
            REG_TEXT_COLOR: text_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A grid dimension of zero behaves as one.
   logic [7:0] cols_eff, rows_eff;
   assign cols_eff = (grid_cols_ff == 8'd0) ? 8'd1 : grid_cols_ff;
   assign rows_eff = (grid_rows_ff == 8'd0) ? 8'd1 : grid_rows_ff;

   // ---------------------------------------------------------------------
   // Sequencer state and control outputs.
   // ---------------------------------------------------------------------
   tcgr_state_type      state_ff, state_in;
   tcgr_div_result_type div_res;

   logic        req_acc;
   logic        out_free;
   logic        need_scroll;
   logic        row_last;
   logic        load_scroll;
   logic        load_row;
   logic        div_start;
   logic        rd_en;
   logic        set_place;
   logic        nl_update;

   logic [15:0] cursor_ff, cursor_in;
   logic [15:0] size_ff, size_in;
   logic [7:0]  code_ff, code_in;
   logic        is_nl_ff, is_nl_in;
   logic        code_ok_ff, code_ok_in;
   logic [ROW_W-1:0] row_idx_ff, row_idx_in;
   logic [12:0] x_ff, x_in;
   logic [12:0] y_ff, y_in;

   assign req_acc     = req_valid && req_ready;
   assign out_free    = !rsp_valid || rsp_ready;
   assign need_scroll = !is_nl_ff && (cursor_ff >= size_ff);
   assign row_last    = (row_idx_ff == ROW_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_func == FUNC_PRINT &&
                (req_char_code == CHAR_NEWLINE || req_char_code >= CHAR_PRINT_MIN)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE:   state_in = ST_SCROLL;
         ST_SCROLL: begin
            if (!need_scroll || out_free) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (div_res.done) begin
               state_in = is_nl_ff ? ST_IDLE : ST_PLACE;
            end
         end
         ST_PLACE:  state_in = ST_ROWS;
         ST_ROWS: begin
            if (out_free && row_last) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready   = 1'b0;
      load_scroll = 1'b0;
      load_row    = 1'b0;
      div_start   = 1'b0;
      rd_en       = 1'b0;
      set_place   = 1'b0;
      nl_update   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready   = 1'b1;
         ST_SCROLL: load_scroll = need_scroll && out_free;
         ST_DSTART: div_start   = 1'b1;
         ST_DIV:    nl_update   = div_res.done && is_nl_ff;
         ST_PLACE: begin
            set_place = 1'b1;
            rd_en     = 1'b1;
         end
         ST_ROWS: begin
            load_row = out_free;
            rd_en    = out_free && !row_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Cursor, grid size and per-character working registers.
   // ---------------------------------------------------------------------
   logic [16:0] nl_next;

   // Newline target: start of the next line, clipped to the grid size.
   assign nl_next = 17'(cursor_ff) - 17'(div_res.remainder) + 17'(cols_eff);

   always_comb begin
      cursor_in = cursor_ff;
      if (load_scroll) begin
         cursor_in = size_ff - 16'(cols_eff);
      end else if (nl_update) begin
         cursor_in = (nl_next > 17'(size_ff)) ? size_ff : nl_next[15:0];
      end else if (load_row && row_last) begin
         cursor_in = cursor_ff + 16'd1;
      end
   end

   always_comb begin
      size_in    = size_ff;
      code_in    = code_ff;
      is_nl_in   = is_nl_ff;
      code_ok_in = code_ok_ff;
      if (state_ff == ST_SIZE) begin
         size_in = 16'(cols_eff) * 16'(rows_eff);
      end
      if (req_acc) begin
         code_in    = req_char_code;
         is_nl_in   = (req_char_code == CHAR_NEWLINE);
         code_ok_in = (int'(req_char_code) < FONT_CHARS);
      end
   end

   // Pixel position of the glyph's top row; y steps down one row per write.
   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      row_idx_in = row_idx_ff;
      if (set_place) begin
         x_in       = 13'(origin_x_ff) + 13'({div_res.remainder, 3'b000});
         y_in       = 13'(origin_y_ff) + 13'(div_res.quotient * GLYPH_ROWS);
         row_idx_in = '0;
      end else if (load_row) begin
         y_in       = y_ff + 13'd1;
         row_idx_in = row_last ? row_idx_ff : row_idx_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
      size_ff    <= size_in;
      code_ff    <= code_in;
      is_nl_ff   <= is_nl_in;
      code_ok_ff <= code_ok_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      row_idx_ff <= row_idx_in;
   end

   // ---------------------------------------------------------------------
   // Shared divider: cursor split into line (quotient) and column (remainder).
   // ---------------------------------------------------------------------
   tcgr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cursor_ff),
      .divisor  (cols_eff),
      .result   (div_res)
   );

   // ---------------------------------------------------------------------
   // Font store. Writes come straight from an accepted font transaction;
   // addresses beyond the store are dropped. Reads run one row ahead of the
   // response register, and the read data holds while the response stalls.
   // ---------------------------------------------------------------------
   logic             font_wr;
   logic [FA_W-1:0]  font_waddr;
   logic [FA_W-1:0]  glyph_base;
   logic [ROW_W-1:0] rd_row;
   logic [FA_W-1:0]  font_raddr;
   logic [7:0]       font_rdata;

   assign font_wr    = req_acc && (req_func == FUNC_FONT) &&
                       (int'(req_font_addr) < FONT_DEPTH);
   assign font_waddr = FA_W'(req_font_addr);
   assign glyph_base = FA_W'(code_ff * GLYPH_ROWS);
   assign rd_row     = set_place ? '0 : row_idx_ff + ROW_W'(1);
   assign font_raddr = glyph_base + FA_W'(rd_row);

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (font_wr),
      .wr_addr (font_waddr),
      .wr_data (req_font_byte),
      .rd_en   (rd_en),
      .rd_addr (font_raddr),
      .rd_data (font_rdata)
   );

   // ---------------------------------------------------------------------
   // Response register. It parts the response side from the sequencer, so
   // the next request can be taken while the final row still waits.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [12:0] rsp_x_ff, rsp_x_in;
   logic [12:0] rsp_y_ff, rsp_y_in;
   logic [31:0] rsp_color_ff, rsp_color_in;
   logic [7:0]  rsp_mask_ff, rsp_mask_in;
   logic        rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_scroll) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_SCROLL;
         rsp_x_in     = 13'(origin_x_ff);
         rsp_y_in     = 13'(origin_y_ff);
         rsp_color_in = '0;
         rsp_mask_in  = '0;
         rsp_last_in  = 1'b0;
      end else if (load_row) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ROW;
         rsp_x_in     = x_ff;
         rsp_y_in     = y_ff;
         rsp_color_in = text_color_ff;
         // Codes beyond the font draw nothing.
         rsp_mask_in  = code_ok_ff ? font_rdata : 8'd0;
         rsp_last_in  = row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_pix_x     = rsp_x_ff;
   assign rsp_pix_y     = rsp_y_ff;
   assign rsp_pix_color = rsp_color_ff;
   assign rsp_row_mask  = rsp_mask_ff;
   assign rsp_last      = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A scroll command is never the final transaction of a character.
   a_scroll_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SCROLL) |-> !rsp_last)
      else $error("scroll transaction marked last");

   // The divider only reports completion while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // The row counter stays within the glyph height while rows are drawn.
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS) |-> (int'(row_idx_ff) < GLYPH_ROWS))
      else $error("glyph row counter out of range");

   // After a character is drawn the cursor lies within the grid.
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      load_row && row_last |=> (cursor_ff <= size_ff) && (state_ff == ST_IDLE))
      else $error("cursor beyond grid after drawing");

   // A scroll moves the cursor to the start of the last line.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      load_scroll |=> (cursor_ff == $past(size_ff) - 16'($past(cols_eff))))
      else $error("cursor not on last line after scroll");

endmodule

@@ hdl/tcgr_ram.sv @@
// ============================================================================
// tcgr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ============================================================================
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tcgr_divider.sv @@
// ============================================================================
// tcgr_divider - iterative restoring divider, 16-bit by 8-bit
// Produces one quotient bit per cycle with a single compare and subtract;
// the quotient and remainder hold until the next start.
// ============================================================================
module tcgr_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [15:0]                  dividend,
   input  logic [7:0]                   divisor,
   output tcgr_pkg::tcgr_div_result_type result
);
   import tcgr_pkg::*;

   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [8:0]  shifted;
   logic [8:0]  diff;
   logic        fits;

   // One restoring step: bring in the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[15]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = (shifted >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[7:0] : shifted[7:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule
